// ===== rtl/adsr_envelope_generator_unit_macros.svh =====
// Assertion macros shared by the envelope generator RTL.
`ifndef ADSR_ENVELOPE_GENERATOR_UNIT_MACROS_SVH
`define ADSR_ENVELOPE_GENERATOR_UNIT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ADSR_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define ADSR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/adsr_eg_pkg.sv =====
// Types, constants and shaping tables of the envelope generator.
package adsr_eg_pkg;

   localparam int LEVEL_FRAC_BITS = 16;
   localparam int PHASE_FRAC_BITS = 24;
   localparam int LOG_TABLE_DEPTH = 256;
   localparam int LOG_BITS        = $clog2(LOG_TABLE_DEPTH);

   localparam int LW      = LEVEL_FRAC_BITS + 1;
   localparam int PW      = PHASE_FRAC_BITS + 1;
   localparam int TIME_W  = 20;
   localparam int MUL_W   = 25;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DATA_W = 24;
   localparam int TAB_W   = 17;

   localparam logic [LW-1:0]     ONE_L    = LW'(1) << LEVEL_FRAC_BITS;
   localparam logic [PW-1:0]     ONE_P    = PW'(1) << PHASE_FRAC_BITS;
   localparam logic [TIME_W-1:0] MIN_TIME = TIME_W'(5);
   localparam logic [7:0]        CURVE_DEAD = 8'd2;
   localparam logic [10:0]       CURVE_GAIN = 11'd9;
   localparam logic [10:0]       CURVE_BASE = 11'd128;
   localparam logic signed [7:0] KEY_ANY  = -8'sd1;

   // request modes
   localparam logic [1:0] MODE_TICK = 2'd0;
   localparam logic [1:0] MODE_ON   = 2'd1;
   localparam logic [1:0] MODE_OFF  = 2'd2;

   // envelope stages
   localparam logic [2:0] STG_IDLE    = 3'd0;
   localparam logic [2:0] STG_ATTACK  = 3'd1;
   localparam logic [2:0] STG_DECAY   = 3'd2;
   localparam logic [2:0] STG_SUSTAIN = 3'd3;
   localparam logic [2:0] STG_RELEASE = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ATTACK_TIME  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DECAY_TIME   = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RELEASE_TIME = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SUSTAIN      = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CURVES       = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_VEL_DEPTHS   = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_AMOUNT       = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_BYPASS       = 4'd7;

   typedef struct packed {
      logic [1:0]        mode;
      logic signed [7:0] note_key;
      logic [15:0]       velocity;
   } req_item_type;

   typedef struct packed {
      logic signed [15:0] level;
      logic [2:0]         stage;
   } rsp_item_type;

   typedef struct packed {
      logic              start;
      logic [TIME_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic          busy;
      logic          done;
      logic [PW-1:0] quotient;
   } div_rsp_type;

   typedef logic [LOG_TABLE_DEPTH-1:0][TAB_W-1:0] tab_type;

   // integer square root, evaluated at elaboration only
   function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      v = v_in;
      r = '0;
      b = 64'd1 << 62;
      for (int it = 0; it < 32; it++) begin
         if (b > v) b = b >> 2;
      end
      for (int it = 0; it < 32; it++) begin
         if (b != 64'd0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
      end
      return r;
   endfunction

   // log2 of a Q30 mantissa in [1,2), Q16 result
   function automatic logic [TAB_W-1:0] mant_log2(input logic [63:0] y_in);
      logic [63:0]      y;
      logic [TAB_W-1:0] res;
      y   = y_in;
      res = '0;
      for (int k = 1; k <= 16; k++) begin
         y = (y * y) >> 30;
         if (y >= (64'd1 << 31)) begin
            y = y >> 1;
            res[16-k] = 1'b1;
         end
      end
      return res;
   endfunction

   function automatic tab_type build_log_tab();
      tab_type     t;
      logic [63:0] m;
      for (int i = 0; i < LOG_TABLE_DEPTH; i++) begin
         m = 64'd65536 + ((64'(i) << 16) / LOG_TABLE_DEPTH);
         t[i] = mant_log2(m << 14);
      end
      return t;
   endfunction

   function automatic tab_type build_exp_tab();
      tab_type     t;
      logic [63:0] roots [17];
      logic [63:0] g;
      logic [63:0] acc;
      roots[0] = 64'd1 << 31;
      for (int k = 1; k <= 16; k++) roots[k] = isqrt64(roots[k-1] << 30);
      for (int i = 0; i < LOG_TABLE_DEPTH; i++) begin
         g   = (64'(i) << 16) / LOG_TABLE_DEPTH;
         acc = 64'd1 << 30;
         for (int k = 1; k <= 16; k++) begin
            if (g[16-k]) acc = (acc * roots[k]) >> 30;
         end
         t[i] = TAB_W'(acc >> 14);
      end
      return t;
   endfunction

   localparam tab_type LOG_TAB = build_log_tab();
   localparam tab_type EXP_TAB = build_exp_tab();

endpackage

// ===== rtl/adsr_eg_div.sv =====
// Restoring divider: full-scale phase over a stage time, one quotient bit a cycle.
module adsr_eg_div (
   input  logic                     clock,
   input  logic                     reset,
   input  adsr_eg_pkg::div_req_type div_req,
   output adsr_eg_pkg::div_rsp_type div_rsp
);
   import adsr_eg_pkg::*;

   localparam int CNT_W = $clog2(PW + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [TIME_W:0]   rem_ff, rem_in;
   logic [PW-1:0]     quo_ff, quo_in;
   logic [TIME_W-1:0] dvs_ff, dvs_in;
   logic [TIME_W:0]   rem_sh;

   // shift in one dividend bit and try a subtract
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      rem_sh  = {rem_ff[TIME_W-1:0], quo_ff[PW-1]};
      if (div_req.start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(PW);
         rem_in  = '0;
         quo_in  = ONE_P;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_in = rem_sh - {1'b0, dvs_ff};
            quo_in = {quo_ff[PW-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[PW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ===== rtl/adsr_envelope_generator_unit.sv =====
// ADSR envelope generator: sequencer around one shared multiplier and a divider.
//
//  port group | direction | handshake         | payload
//  req_       | in        | req_valid/stall   | req_item_type: mode, note_key, velocity
//  rsp_       | out       | rsp_valid/stall   | rsp_item_type: level, stage
//  csr_       | in        | csr_valid/ready   | csr_index, csr_data
//
// A tick passes through the output states (peak, amount, write) when idle, sustained or bypassed,
// and first through shape and mix when the phase advances, with normalize, log and exp
// between them when a curve is active, and a wait while the decay step is divided when attack ends.
// A note-on runs its velocity, attack and set states and then waits on the serial divider;
// a note-off waits on it at once; an ignored request leaves the sequencer idle.
// req_stall is high while a request is at work; one result waits in the output
// register, so the next request is taken while rsp_stall holds it.
// Reset is synchronous; no clearing pass follows it.
`include "adsr_envelope_generator_unit_macros.svh"

module adsr_envelope_generator_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  adsr_eg_pkg::req_item_type            req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output adsr_eg_pkg::rsp_item_type            rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [adsr_eg_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [adsr_eg_pkg::CSR_DATA_W-1:0]   csr_data
);
   import adsr_eg_pkg::*;

   localparam int ST_W   = 4;
   localparam int NCNT_W = $clog2(PHASE_FRAC_BITS);

   localparam logic [ST_W-1:0] ST_IDLE      = 4'd0;
   localparam logic [ST_W-1:0] ST_ON_VT     = 4'd1;
   localparam logic [ST_W-1:0] ST_ON_ATT    = 4'd2;
   localparam logic [ST_W-1:0] ST_ON_VA     = 4'd3;
   localparam logic [ST_W-1:0] ST_ON_SET    = 4'd4;
   localparam logic [ST_W-1:0] ST_WAIT_CFG  = 4'd5;
   localparam logic [ST_W-1:0] ST_SHAPE     = 4'd6;
   localparam logic [ST_W-1:0] ST_NORM      = 4'd7;
   localparam logic [ST_W-1:0] ST_LOG       = 4'd8;
   localparam logic [ST_W-1:0] ST_EXP       = 4'd9;
   localparam logic [ST_W-1:0] ST_MIX       = 4'd10;
   localparam logic [ST_W-1:0] ST_MIX2      = 4'd11;
   localparam logic [ST_W-1:0] ST_WAIT_TICK = 4'd12;
   localparam logic [ST_W-1:0] ST_OUT_PK    = 4'd13;
   localparam logic [ST_W-1:0] ST_OUT_AMT   = 4'd14;
   localparam logic [ST_W-1:0] ST_OUT_WR    = 4'd15;

   // configuration registers
   logic [TIME_W-1:0]  attack_time_ff, decay_time_ff, release_time_ff;
   logic [15:0]        sustain_ff;
   logic [23:0]        curves_ff;
   logic [15:0]        vel_depths_ff;
   logic signed [15:0] amount_ff;
   logic               bypass_ff;

   // envelope state
   logic [ST_W-1:0]   state_ff, state_in;
   logic [2:0]        stage_ff, stage_in;
   logic [LW-1:0]     cur_ff, cur_in;
   logic [LW-1:0]     start_ff, start_in;
   logic [LW-1:0]     tgt_ff, tgt_in;
   logic [PW-1:0]     phase_ff, phase_in;
   logic [PW-1:0]     step_ff, step_in;
   logic signed [7:0] curve_ff, curve_in;
   logic [LW-1:0]     peak_ff, peak_in;
   logic signed [7:0] held_ff, held_in;

   // work registers
   req_item_type       req_ff;
   logic [PHASE_FRAC_BITS-1:0] norm_ff, norm_in;
   logic [NCNT_W-1:0]  ncnt_ff, ncnt_in;
   logic               neg_ff, neg_in;
   logic [PW-1:0]      shp_ff, shp_in;
   logic [PROD_W-1:0]  prod_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_data_ff, rsp_data_in;

   // combinational helpers
   logic               req_fire;
   logic [MUL_W-1:0]   mul_a, mul_b;
   logic               mul_en;
   div_req_type        div_req;
   div_rsp_type        div_rsp;
   logic [7:0]         vamp, vtime;
   logic [LW-1:0]      sus_lvl;
   logic [7:0]         curve_mag;
   logic [10:0]        f7;
   logic [PW:0]        phase_sum;
   logic [PW-1:0]      shape_u;
   logic [PW-1:0]      factor;
   logic [TIME_W-1:0]  att_len;
   logic [LOG_BITS-1:0] log_idx, exp_idx;
   logic [21:0]        nlog;
   logic [25:0]        e_val;
   logic [9:0]         q_val;
   logic [15:0]        g_val;
   logic [PW-1:0]      pow_v, pow_p;
   logic [LW-1:0]      diff, delta;
   logic               rising;
   logic [LW-1:0]      mag;
   logic [16:0]        abs_amt;
   logic [15:0]        out_m;
   logic [PW-1:0]      div_step;

   assign req_fire  = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign vamp      = vel_depths_ff[7:0];
   assign vtime     = vel_depths_ff[15:8];
   assign sus_lvl   = LW'(sustain_ff);
   assign curve_mag = curve_ff[7] ? 8'(-curve_ff) : 8'(curve_ff);
   assign f7        = CURVE_BASE + CURVE_GAIN * 11'(curve_mag);
   assign phase_sum = {1'b0, phase_ff} + {1'b0, step_ff};
   assign abs_amt   = amount_ff[15] ? 17'(-{amount_ff[15], amount_ff})
                                    : 17'({1'b0, amount_ff});
   assign div_step  = (div_rsp.quotient == '0) ? PW'(1) : div_rsp.quotient;

   // note-on arithmetic
   assign factor  = (PW'(1) << 24) - PW'(prod_ff[23:0]);
   assign att_len = prod_ff[24 +: TIME_W];

   // power curve: log of the normalized phase, scaled, then exp back
   assign log_idx = norm_ff[PHASE_FRAC_BITS-2 -: LOG_BITS];
   assign nlog    = (22'(ncnt_ff) + 22'd1) * 22'd65536 - 22'(LOG_TAB[log_idx]);
   assign e_val   = prod_ff[7 +: 26];
   assign q_val   = 10'((27'(e_val) + 27'h0FFFF) >> 16);
   assign g_val   = 16'(-e_val);
   assign exp_idx = g_val[15 -: LOG_BITS];
   assign pow_v   = (PW'(EXP_TAB[exp_idx]) << (PHASE_FRAC_BITS - 16)) >> q_val;
   assign pow_p   = (pow_v > ONE_P) ? ONE_P : pow_v;

   // interpolation and output scaling
   assign rising  = (tgt_ff >= start_ff);
   assign diff    = rising ? (tgt_ff - start_ff) : (start_ff - tgt_ff);
   assign delta   = prod_ff[PHASE_FRAC_BITS +: LW];
   assign mag     = prod_ff[LEVEL_FRAC_BITS +: LW];
   assign out_m   = prod_ff[LEVEL_FRAC_BITS +: 16];

   // pick the shaped input: phase for convex curves, its complement otherwise
   assign shape_u = curve_ff[7] ? (ONE_P - phase_ff) : phase_ff;

   // select multiplier operands
   always_comb begin
      mul_en = 1'b1;
      mul_a  = '0;
      mul_b  = '0;
      unique case (state_ff)
         ST_ON_VT: begin
            mul_a = MUL_W'(req_ff.velocity);
            mul_b = MUL_W'(vtime);
         end
         ST_ON_ATT: begin
            mul_a = MUL_W'(attack_time_ff);
            mul_b = MUL_W'(factor);
         end
         ST_ON_VA: begin
            mul_a = MUL_W'(req_ff.velocity);
            mul_b = MUL_W'(vamp);
         end
         ST_LOG: begin
            mul_a = MUL_W'(nlog);
            mul_b = MUL_W'(f7);
         end
         ST_MIX: begin
            mul_a = MUL_W'(diff);
            mul_b = MUL_W'(shp_ff);
         end
         ST_OUT_PK: begin
            mul_a = MUL_W'(cur_ff);
            mul_b = MUL_W'(peak_ff);
         end
         ST_OUT_AMT: begin
            mul_a = MUL_W'(mag);
            mul_b = MUL_W'(abs_amt);
         end
         default: mul_en = 1'b0;
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      stage_in     = stage_ff;
      cur_in       = cur_ff;
      start_in     = start_ff;
      tgt_in       = tgt_ff;
      phase_in     = phase_ff;
      step_in      = step_ff;
      curve_in     = curve_ff;
      peak_in      = peak_ff;
      held_in      = held_ff;
      norm_in      = norm_ff;
      ncnt_in      = ncnt_ff;
      neg_in       = neg_ff;
      shp_in       = shp_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      div_req.start   = 1'b0;
      div_req.divisor = MIN_TIME;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_data.mode)
                  MODE_ON: state_in = ST_ON_VT;
                  MODE_OFF: begin
                     if ((held_ff == req_data.note_key || req_data.note_key == KEY_ANY)
                         && stage_ff != STG_IDLE) begin
                        stage_in        = STG_RELEASE;
                        start_in        = cur_ff;
                        tgt_in          = '0;
                        phase_in        = '0;
                        curve_in        = curves_ff[23:16];
                        div_req.start   = 1'b1;
                        div_req.divisor = (release_time_ff < MIN_TIME) ? MIN_TIME
                                                                      : release_time_ff;
                        state_in        = ST_WAIT_CFG;
                     end
                  end
                  MODE_TICK: begin
                     state_in = ST_OUT_PK;
                     if (bypass_ff) begin
                        if (stage_ff == STG_RELEASE) begin
                           cur_in   = '0;
                           stage_in = STG_IDLE;
                           held_in  = KEY_ANY;
                        end else if (stage_ff != STG_IDLE) begin
                           cur_in = ONE_L;
                        end
                     end else if (stage_ff == STG_SUSTAIN) begin
                        cur_in = sus_lvl;
                     end else if (stage_ff != STG_IDLE) begin
                        phase_in = (phase_sum > {1'b0, ONE_P}) ? ONE_P : PW'(phase_sum);
                        state_in = ST_SHAPE;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_ON_VT:  state_in = ST_ON_ATT;
         ST_ON_ATT: state_in = ST_ON_VA;
         ST_ON_VA: begin
            div_req.start   = 1'b1;
            div_req.divisor = (att_len < MIN_TIME) ? MIN_TIME : att_len;
            state_in        = ST_ON_SET;
         end
         ST_ON_SET: begin
            peak_in  = ONE_L - (LW'(vamp) << (LEVEL_FRAC_BITS - 8))
                       + LW'(prod_ff[23:0] >> (24 - LEVEL_FRAC_BITS));
            held_in  = req_ff.note_key;
            stage_in = STG_ATTACK;
            start_in = cur_ff;
            tgt_in   = ONE_L;
            phase_in = '0;
            curve_in = curves_ff[7:0];
            state_in = ST_WAIT_CFG;
         end
         ST_WAIT_CFG: begin
            if (div_rsp.done) begin
               step_in  = div_step;
               state_in = ST_IDLE;
            end
         end
         ST_SHAPE: begin
            neg_in   = curve_ff[7];
            state_in = ST_MIX;
            if (curve_mag < CURVE_DEAD) begin
               shp_in = phase_ff;
            end else if (shape_u == '0) begin
               shp_in = curve_ff[7] ? ONE_P : '0;
            end else if (shape_u >= ONE_P) begin
               shp_in = curve_ff[7] ? '0 : ONE_P;
            end else begin
               norm_in  = shape_u[PHASE_FRAC_BITS-1:0];
               ncnt_in  = '0;
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            // shift up until the leading one reaches the top bit
            if (norm_ff[PHASE_FRAC_BITS-1]) begin
               state_in = ST_LOG;
            end else begin
               norm_in = norm_ff << 1;
               ncnt_in = ncnt_ff + NCNT_W'(1);
            end
         end
         ST_LOG: state_in = ST_EXP;
         ST_EXP: begin
            shp_in   = neg_ff ? (ONE_P - pow_p) : pow_p;
            state_in = ST_MIX;
         end
         ST_MIX: state_in = ST_MIX2;
         ST_MIX2: begin
            cur_in   = rising ? (start_ff + delta) : (start_ff - delta);
            state_in = ST_OUT_PK;
            if (phase_ff >= ONE_P) begin
               if (stage_ff == STG_ATTACK) begin
                  stage_in        = STG_DECAY;
                  start_in        = ONE_L;
                  tgt_in          = sus_lvl;
                  phase_in        = '0;
                  curve_in        = curves_ff[15:8];
                  div_req.start   = 1'b1;
                  div_req.divisor = (decay_time_ff < MIN_TIME) ? MIN_TIME : decay_time_ff;
                  state_in        = ST_WAIT_TICK;
               end else if (stage_ff == STG_DECAY) begin
                  stage_in = STG_SUSTAIN;
                  cur_in   = sus_lvl;
               end else begin
                  cur_in   = '0;
                  stage_in = STG_IDLE;
                  held_in  = KEY_ANY;
               end
            end
         end
         ST_WAIT_TICK: begin
            if (div_rsp.done) begin
               step_in  = div_step;
               state_in = ST_OUT_PK;
            end
         end
         ST_OUT_PK:  state_in = ST_OUT_AMT;
         ST_OUT_AMT: state_in = ST_OUT_WR;
         ST_OUT_WR: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_in.level = amount_ff[15] ? 16'(-out_m) : out_m;
               rsp_data_in.stage = stage_ff;
               rsp_valid_in      = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   adsr_eg_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         attack_time_ff  <= TIME_W'(480);
         decay_time_ff   <= TIME_W'(4800);
         release_time_ff <= TIME_W'(24000);
         sustain_ff      <= 16'd32768;
         curves_ff       <= '0;
         vel_depths_ff   <= 16'd255;
         amount_ff       <= 16'sd32767;
         bypass_ff       <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_ATTACK_TIME:  attack_time_ff  <= csr_data[TIME_W-1:0];
            REG_DECAY_TIME:   decay_time_ff   <= csr_data[TIME_W-1:0];
            REG_RELEASE_TIME: release_time_ff <= csr_data[TIME_W-1:0];
            REG_SUSTAIN:      sustain_ff      <= csr_data[15:0];
            REG_CURVES:       curves_ff       <= csr_data[23:0];
            REG_VEL_DEPTHS:   vel_depths_ff   <= csr_data[15:0];
            REG_AMOUNT:       amount_ff       <= csr_data[15:0];
            REG_BYPASS:       bypass_ff       <= csr_data[0];
            default: ;
         endcase
      end
   end

   // state and work registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         stage_ff     <= STG_IDLE;
         cur_ff       <= '0;
         start_ff     <= '0;
         tgt_ff       <= '0;
         phase_ff     <= '0;
         step_ff      <= '0;
         curve_ff     <= '0;
         peak_ff      <= '0;
         held_ff      <= KEY_ANY;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         stage_ff     <= stage_in;
         cur_ff       <= cur_in;
         start_ff     <= start_in;
         tgt_ff       <= tgt_in;
         phase_ff     <= phase_in;
         step_ff      <= step_in;
         curve_ff     <= curve_in;
         peak_ff      <= peak_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_fire) req_ff <= req_data;
      if (mul_en) prod_ff <= mul_a * mul_b;
      norm_ff     <= norm_in;
      ncnt_ff     <= ncnt_in;
      neg_ff      <= neg_in;
      shp_ff      <= shp_in;
      rsp_data_ff <= rsp_data_in;
   end

   `ADSR_ASSERT_SAME(a_idle_no_key, stage_ff == STG_IDLE, held_ff == KEY_ANY, "idle with a held key")
   `ADSR_ASSERT_SAME(a_phase_limit, 1'b1, phase_ff <= ONE_P, "phase beyond full scale")
   `ADSR_ASSERT_NEXT(a_tick_busy, req_fire && req_data.mode == MODE_TICK, state_ff != ST_IDLE, "tick dropped")
   `ADSR_ASSERT_SAME(a_div_wait, state_ff == ST_WAIT_CFG || state_ff == ST_WAIT_TICK, div_rsp.busy || div_rsp.done, "waiting on an idle divider")

endmodule
